[design/bsws_pkg.sv]
// ----------------------------------------------------------------------------
// bsws_pkg
// shared types and codes for the byte stack with search
// ----------------------------------------------------------------------------
package bsws_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND  = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [BYTE_W-1:0]  data;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_out_item;

    // sequencer to compare unit
    typedef struct packed {
        logic             advance;
        logic             issue;
        logic [POS_W-1:0] pos;
    } t_scan_ctl;

    // compare unit to sequencer
    typedef struct packed {
        logic             tag_valid;
        logic             match;
        logic [POS_W-1:0] pos;
    } t_scan_hit;

endpackage

[design/bsws_if.sv]
// ----------------------------------------------------------------------------
// bsws stream interfaces
// valid/ready channels for command and result transactions
// ----------------------------------------------------------------------------
interface bsws_in_if;
    import bsws_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bsws_out_if;
    import bsws_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/bsws_mem.sv]
// ----------------------------------------------------------------------------
// bsws_mem
// stack storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module bsws_mem #(
    parameter int DEPTH = bsws_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [bsws_pkg::BYTE_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [bsws_pkg::BYTE_W-1:0] o_rdata
);
    import bsws_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/bsws_scan.sv]
// ----------------------------------------------------------------------------
// bsws_scan
// shared key compare unit with the tag of the read in flight
// ----------------------------------------------------------------------------
module bsws_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load_key,
    input  logic [bsws_pkg::BYTE_W-1:0] i_key,
    input  bsws_pkg::t_scan_ctl         i_ctl,
    input  logic [bsws_pkg::BYTE_W-1:0] i_rdata,
    output bsws_pkg::t_scan_hit         o_hit
);
    import bsws_pkg::*;

    logic [BYTE_W-1:0] r_key;
    logic              r_tag_valid;
    logic [POS_W-1:0]  r_tag_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_valid <= 1'b0;
        end else if (i_ctl.advance) begin
            r_tag_valid <= i_ctl.issue;
        end
        if (i_ctl.advance) begin
            r_tag_pos <= i_ctl.pos;
        end
        if (i_load_key) begin
            r_key <= i_key;
        end
    end

    // read data belongs to the tagged entry in the cycle after its issue
    assign o_hit.tag_valid = r_tag_valid;
    assign o_hit.match     = r_tag_valid && (i_rdata == r_key);
    assign o_hit.pos       = r_tag_pos;

endmodule

[design/byte_stack_with_search.sv]
// ----------------------------------------------------------------------------
// byte_stack_with_search
// bounded byte stack with push, pop and search by key
// ----------------------------------------------------------------------------
// usage:
//   i_in carries command transactions (cmd, value); o_out carries result
//   transactions (status, data, position, count, last). both are valid/ready.
//   push and pop give one result; search gives one result per matching entry,
//   bottom to top, the final one marked by last, or a single not-found result.
//   every result reports the entry count after the command.
// sequence:
//   push, rejected pop and search on an empty stack: result registered on
//   accept. pop: registered memory read, then S_POP registers the result.
//   search: the sequencer walks the entries one per cycle, holding while a
//   match waits on a stalled output, through the single compare unit, so
//   the search time is set by the number of held entries.
//   throughput: a push every cycle with the receiver ready; the input is
//   not ready while a pop or search is in progress.
// reset: synchronous active low; the stack comes up empty, memory contents
//   are left as they are (only held entries are ever read), no clearing pass.
// stall: when o_out.ready is low the result stays in the output register and
//   the scan holds once it has another result to send; nothing is dropped.
// ----------------------------------------------------------------------------
module byte_stack_with_search #(
    parameter int DEPTH = bsws_pkg::DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bsws_in_if.sink           i_in,
    bsws_out_if.source        o_out
);
    import bsws_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]      r_state, n_state;
    logic [CW-1:0]   r_count, n_count;   // held entries
    logic [CW-1:0]   r_idx,   n_idx;     // next entry to read during search
    logic            r_have,  n_have;    // a match is held back until the next one
    logic [POS_W-1:0] r_pend, n_pend;    // position of the held match
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out,   n_out;

    logic              slot_free;
    logic              in_acc;
    logic              full;
    logic              empty;
    logic              issue_ok;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;
    logic              load_key;
    t_scan_ctl         scan_ctl;
    t_scan_hit         scan_hit;

    // output register frees up in the same cycle it is taken
    assign slot_free  = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && slot_free;
    assign in_acc     = i_in.valid && i_in.ready;
    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);
    assign issue_ok   = (r_idx < r_count);

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    bsws_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(r_count)),
        .i_wdata (i_in.data.value),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bsws_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load_key (load_key),
        .i_key      (i_in.data.value),
        .i_ctl      (scan_ctl),
        .i_rdata    (mem_rdata),
        .o_hit      (scan_hit)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_have      = r_have;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = AW'(r_idx);
        load_key    = 1'b0;
        scan_ctl    = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in.data.cmd)
                        CMD_PUSH: begin
                            n_out_valid = 1'b1;
                            if (full) begin
                                // byte dropped, count unchanged
                                n_out = '{status: STAT_OVERFLOW, data: '0, position: '0,
                                          count: COUNT_W'(r_count), last: 1'b1};
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + CW'(1);
                                n_out   = '{status: STAT_OK, data: '0, position: '0,
                                            count: COUNT_W'(n_count), last: 1'b1};
                            end
                        end
                        CMD_POP: begin
                            if (empty) begin
                                n_out_valid = 1'b1;
                                n_out = '{status: STAT_UNDERFLOW, data: '0, position: '0,
                                          count: '0, last: 1'b1};
                            end else begin
                                // read the top entry, S_POP sends the result
                                n_count   = r_count - CW'(1);
                                mem_re    = 1'b1;
                                mem_raddr = AW'(r_count - CW'(1));
                                n_state   = S_POP;
                            end
                        end
                        CMD_SEARCH: begin
                            if (empty) begin
                                n_out_valid = 1'b1;
                                n_out = '{status: STAT_NOTFOUND, data: '0, position: '0,
                                          count: '0, last: 1'b1};
                            end else begin
                                load_key = 1'b1;
                                n_idx    = '0;
                                n_have   = 1'b0;
                                n_state  = S_SCAN;
                            end
                        end
                        default: begin
                            // unused command code: taken and ignored
                        end
                    endcase
                end
            end

            S_POP: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{status: STAT_OK, data: mem_rdata, position: '0,
                              count: COUNT_W'(r_count), last: 1'b1};
                    n_state = S_IDLE;
                end
            end

            S_SCAN: begin
                if (!scan_hit.tag_valid && !issue_ok) begin
                    // all entries compared; flush the held match or report none
                    if (slot_free) begin
                        n_out_valid = 1'b1;
                        if (r_have) begin
                            n_out = '{status: STAT_OK, data: '0, position: r_pend,
                                      count: COUNT_W'(r_count), last: 1'b1};
                        end else begin
                            n_out = '{status: STAT_NOTFOUND, data: '0, position: '0,
                                      count: COUNT_W'(r_count), last: 1'b1};
                        end
                        n_state = S_IDLE;
                    end
                end else if (!(scan_hit.match && r_have && !slot_free)) begin
                    // pipeline moves: issue the next read, retire the tagged compare
                    scan_ctl.advance = 1'b1;
                    scan_ctl.issue   = issue_ok;
                    scan_ctl.pos     = POS_W'(r_idx);
                    if (issue_ok) begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(r_idx);
                        n_idx     = r_idx + CW'(1);
                    end
                    if (scan_hit.match) begin
                        n_have = 1'b1;
                        n_pend = scan_hit.pos;
                        if (r_have) begin
                            // a later match exists, so the held one is not last
                            n_out_valid = 1'b1;
                            n_out = '{status: STAT_OK, data: '0, position: r_pend,
                                      count: COUNT_W'(r_count), last: 1'b0};
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
        end
        r_idx  <= n_idx;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

`ifndef SYNTHESIS
    // the stack never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    // the scan pointer stays within the held entries
    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_count))
        else $error("scan pointer past top of stack");

    // every error or not-found result closes its command
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.data.status != STAT_OK)) |-> o_out.data.last)
        else $error("error result without last");

    // a push onto a stack that is not full adds exactly one entry
    a_push_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.data.cmd == CMD_PUSH) && !full)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the stack");
`endif

endmodule

[verif/byte_stack_with_search_checker.sv]
// ----------------------------------------------------------------------------
// byte_stack_with_search_checker
// watches the command and result channels, keeps its own copy of the stack,
// works out the results each command must give and compares them in order
// ----------------------------------------------------------------------------
module byte_stack_with_search_checker #(
    parameter int DEPTH = bsws_pkg::DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  logic                 i_cmd_ready,
    input  bsws_pkg::t_in_item   i_cmd_data,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  bsws_pkg::t_out_item  i_res_data,
    output int                   o_due_count,
    output int                   o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import bsws_pkg::*;

    logic [BYTE_W-1:0] stack_bytes [DEPTH];
    int                held;
    t_out_item         results_due [$];

    initial begin
        o_due_count  = 0;
        o_fail_count = 0;
        held         = 0;
    end

    // expected results of one command, appended in output order
    function automatic void stack_op_results(t_in_item item);
        t_out_item r;
        t_out_item prev_hit;
        int        hits;
        r      = '0;
        r.last = 1'b1;
        hits   = 0;
        case (item.cmd)
            CMD_PUSH: begin
                if (held >= DEPTH) begin
                    r.status = STAT_OVERFLOW;
                end else begin
                    stack_bytes[held] = item.value;
                    held++;
                    r.status = STAT_OK;
                end
                r.count = COUNT_W'(held);
                results_due.push_back(r);
            end
            CMD_POP: begin
                if (held == 0) begin
                    r.status = STAT_UNDERFLOW;
                end else begin
                    held--;
                    r.status = STAT_OK;
                    r.data   = stack_bytes[held];
                end
                r.count = COUNT_W'(held);
                results_due.push_back(r);
            end
            CMD_SEARCH: begin
                r.count = COUNT_W'(held);
                for (int i = 0; i < held; i++) begin
                    if (stack_bytes[i] == item.value) begin
                        if (hits > 0) results_due.push_back(prev_hit);
                        prev_hit          = r;
                        prev_hit.status   = STAT_OK;
                        prev_hit.position = POS_W'(i);
                        prev_hit.last     = 1'b0;
                        hits++;
                    end
                end
                if (hits == 0) begin
                    r.status = STAT_NOTFOUND;
                    results_due.push_back(r);
                end else begin
                    prev_hit.last = 1'b1;
                    results_due.push_back(prev_hit);
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        bit        ok;
        if (!i_rst_n) begin
            held = 0;
            results_due.delete();
        end else begin
            // a result always trails its command, so compare before predicting
            if (i_res_valid && i_res_ready) begin
                if (results_due.size() == 0) begin
                    $error("result transaction with no expectation waiting: %p", i_res_data);
                    o_fail_count++;
                end else begin
                    want = results_due.pop_front();
                    ok = field_ok("status", 32'(want.status), 32'(i_res_data.status))
                       & field_ok("data", 32'(want.data), 32'(i_res_data.data))
                       & field_ok("position", 32'(want.position),
                                  32'(i_res_data.position))
                       & field_ok("count", 32'(want.count), 32'(i_res_data.count))
                       & field_ok("last", 32'(want.last), 32'(i_res_data.last));
                    if (!ok) o_fail_count++;
                end
            end
            if (i_cmd_valid && i_cmd_ready) stack_op_results(i_cmd_data);
        end
        o_due_count = results_due.size();
    end

endmodule

[verif/byte_stack_with_search_tb.sv]
// ----------------------------------------------------------------------------
// byte_stack_with_search_tb
// drives push, pop and search commands into the byte stack and lets the
// checker compare every result transaction against its own stack model
// ----------------------------------------------------------------------------
module byte_stack_with_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsws_pkg::*;

    // cmd encoding the block ignores
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // generous: every result stalled a while, every search a full walk
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 350;
    localparam int LONG_HOLD_LEN = 300;
    localparam int DRAIN_CYCLES  = DEPTH_DEF + 16;

    logic i_clk;
    logic i_rst_n;

    bsws_in_if  cmd_if ();
    bsws_out_if res_if ();

    int due_count;
    int fail_count;

    // sender burst state
    int burst_left;
    bit steady;
    int sent_count;

    // handshake between sender and receiver for the one long hold-off
    bit long_hold_req;
    bit long_hold_done;

    byte_stack_with_search dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    byte_stack_with_search_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_if.valid),
        .i_cmd_ready  (cmd_if.ready),
        .i_cmd_data   (cmd_if.data),
        .i_res_valid  (res_if.valid),
        .i_res_ready  (res_if.ready),
        .i_res_data   (res_if.data),
        .o_due_count  (due_count),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run-away guard
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // offer one command at the falling edge and hold it until the block takes
    // it; after the transaction either keep the burst going or open a gap
    task automatic issue_cmd(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] v);
        t_in_item item;
        item.cmd   = c;
        item.value = v;
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= item;
        // ready read at the rising edge, before the block's registers move
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (c != CMD_UNUSED) sent_count++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 16);
            if (!steady) begin
                cmd_if.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
        end
    endtask

    // sender pause: nothing offered until every predicted result has come out
    task automatic wait_for_results();
        cmd_if.valid <= 1'b0;
        while (due_count != 0) @(negedge i_clk);
    endtask

    // receiver: its own pattern of ready stretches, fully open, mostly open or
    // mostly closed, plus one long hold-off when the sender asks for it
    initial begin
        int mode;
        int span;
        int hold_cycles;
        res_if.ready   = 1'b0;
        long_hold_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 60);
            repeat (span) begin
                @(negedge i_clk);
                if (long_hold_req && !long_hold_done) begin
                    // the sender keeps offering, so the block backs up and
                    // drops its input ready
                    res_if.ready <= 1'b0;
                    hold_cycles = 0;
                    while (hold_cycles < LONG_HOLD_LEN) begin
                        @(negedge i_clk);
                        hold_cycles++;
                    end
                    long_hold_done = 1'b1;
                end
                case (mode)
                    0: res_if.ready <= 1'b1;
                    1: res_if.ready <= ($urandom_range(0, 3) != 0);
                    default: res_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // stimulus
    initial begin
        logic [BYTE_W-1:0] key;
        logic [CMD_W-1:0]  c;
        int                r;
        int                push_lim;
        int                pop_lim;
        int                span;
        int                target;
        bit                narrow;

        i_rst_n       = 1'b0;
        cmd_if.valid  = 1'b0;
        cmd_if.data   = '0;
        long_hold_req = 1'b0;
        burst_left    = 0;
        steady        = 1'b0;
        sent_count    = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // directed: empty-stack corner cases first
        issue_cmd(CMD_POP, 8'h00);       // underflow
        issue_cmd(CMD_SEARCH, 8'h00);    // not found on an empty stack
        issue_cmd(CMD_UNUSED, 8'h00);    // ignored, no result
        // extreme and alternating byte patterns
        issue_cmd(CMD_PUSH, 8'h00);
        issue_cmd(CMD_PUSH, 8'hFF);
        issue_cmd(CMD_PUSH, 8'hA5);
        issue_cmd(CMD_PUSH, 8'h5A);
        issue_cmd(CMD_PUSH, 8'hFF);
        issue_cmd(CMD_SEARCH, 8'hFF);    // two hits, second one marked last
        issue_cmd(CMD_SEARCH, 8'h00);    // single hit at the bottom
        issue_cmd(CMD_SEARCH, 8'h77);    // not found on a non-empty stack
        issue_cmd(CMD_UNUSED, 8'hFF);
        issue_cmd(CMD_POP, 8'h00);
        issue_cmd(CMD_SEARCH, 8'hFF);    // popped entry no longer matches
        issue_cmd(CMD_POP, 8'hFF);
        issue_cmd(CMD_POP, 8'h00);
        issue_cmd(CMD_POP, 8'h00);
        issue_cmd(CMD_POP, 8'h00);
        issue_cmd(CMD_POP, 8'h00);       // underflow again after draining
        issue_cmd(CMD_SEARCH, 8'hFF);

        // full stack: start empty, fill to the brim under a long receiver
        // hold-off, then overflow and a search that hits top and bottom
        wait_for_results();
        long_hold_req = 1'b1;
        steady        = 1'b1;
        key           = BYTE_W'($urandom_range(0, 255));
        for (int i = 0; i < DEPTH_DEF; i++) begin
            if (i == 0 || i == DEPTH_DEF - 1 || $urandom_range(0, 1) == 1)
                issue_cmd(CMD_PUSH, key);
            else
                issue_cmd(CMD_PUSH, BYTE_W'($urandom_range(0, 255)));
        end
        issue_cmd(CMD_PUSH, ~key);       // overflow, dropped
        issue_cmd(CMD_PUSH, key);        // overflow, dropped
        issue_cmd(CMD_SEARCH, key);      // hits at position 0 and the top
        issue_cmd(CMD_SEARCH, ~key);
        issue_cmd(CMD_POP, 8'h00);
        issue_cmd(CMD_PUSH, key);
        issue_cmd(CMD_PUSH, key);        // overflow once more
        wait_for_results();

        // random phases: fill-heavy, mixed and drain-heavy, with a narrow key
        // set in some so that searches find several hits
        target = sent_count + RANDOM_ITEMS - 70;
        while (sent_count < target) begin
            narrow = ($urandom_range(0, 1) == 1);
            steady = ($urandom_range(0, 3) == 0);
            span   = $urandom_range(30, 70);
            case ($urandom_range(0, 2))
                0: begin push_lim = 65; pop_lim = 78; end
                1: begin push_lim = 40; pop_lim = 70; end
                default: begin push_lim = 15; pop_lim = 70; end
            endcase
            repeat (span) begin
                r = $urandom_range(0, 99);
                if (r < push_lim)     c = CMD_PUSH;
                else if (r < pop_lim) c = CMD_POP;
                else if (r < 96)      c = CMD_SEARCH;
                else                  c = CMD_UNUSED;
                issue_cmd(c, narrow ? BYTE_W'($urandom_range(0, 3))
                                    : BYTE_W'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 4) == 0) wait_for_results();
        end

        // everything accepted: let the block drain, then give the verdict
        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[byte_stack_with_search.f]
design/bsws_pkg.sv
design/bsws_if.sv
design/bsws_mem.sv
design/bsws_scan.sv
design/byte_stack_with_search.sv
verif/byte_stack_with_search_checker.sv
verif/byte_stack_with_search_tb.sv
